@@ design/voltage_to_pwm_compare_core_assert.svh @@
// Assertion macros for the PWM compare core.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef VOLTAGE_TO_PWM_COMPARE_CORE_ASSERT_SVH
`define VOLTAGE_TO_PWM_COMPARE_CORE_ASSERT_SVH

// Same-cycle implication.
`define VPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/vpc_pkg.sv @@
package vpc_pkg;

    // Compare counter width default
    localparam int VPC_COUNT_WIDTH = 16;

    // APB register map
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SUPPLY_MV    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_MV     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FRAC_OFFSET  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_ALIGN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_USE_FRACTION = 3'd5;

    // Register reset values
    localparam logic [15:0] PERIOD_RST     = 16'd1023;
    localparam logic [15:0] SUPPLY_RST     = 16'd12000;
    localparam logic [15:0] LIMIT_RST      = 16'd12000;
    localparam logic [1:0]  FRAC_OFS_RST   = 2'd0;
    localparam logic        CENTER_RST     = 1'b1;
    localparam logic        USE_FRAC_RST   = 1'b1;

    // Duty scaling (hundredths of a percent)
    localparam logic [13:0] DUTY_FULL        = 14'd10000;
    localparam logic [16:0] DUTY_CENTER_DIV  = 17'd20000;
    localparam logic [16:0] DUTY_CENTER_RND  = 17'd10000;
    localparam logic [16:0] DUTY_EDGE_DIV    = 17'd10000;

    // Serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = 36;

    typedef enum logic [1:0] {
        FN_APPLY_V    = 2'd0,
        FN_STAGE_V    = 2'd1,
        FN_COMMIT     = 2'd2,
        FN_APPLY_DUTY = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_CLAMP,
        S_PLACE
    } t_state;

endpackage

@@ design/vpc_if.sv @@
// Command channel
interface vpc_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [15:0] speed_mv;
    logic signed [14:0] duty_centi;

    modport source (output valid, output func, output speed_mv, output duty_centi,
                    input ready);
    modport sink   (input valid, input func, input speed_mv, input duty_centi,
                    output ready);
endinterface

// Result channel
interface vpc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] rise_compare;
    logic [15:0] fall_compare;
    logic [1:0]  fraction_bits;
    logic        pending;
    logic        applied;

    modport source (output valid, output rise_compare, output fall_compare,
                    output fraction_bits, output pending, output applied, input ready);
    modport sink   (input valid, input rise_compare, input fall_compare,
                    input fraction_bits, input pending, input applied, output ready);
endinterface

@@ design/voltage_to_pwm_compare_core.sv @@
// PWM compare core: turns a signed millivolt command or a duty in 0.01 % into
// compare values for a center-aligned or edge-aligned PWM timer.
// i_cmd (valid/ready) carries func, speed_mv and duty_centi; o_res carries the
// live rise/fall compares, fraction bits, the pending flag and the applied flag.
// One result per command transfer.
// Voltage and duty commands run through one multiplier pass and a restoring
// divider that produces one quotient bit per cycle; the result becomes valid
// when i_cmd.ready also returns, so no new command is taken until the
// previous one is through. A commit skips the arithmetic and goes straight to
// placement.
// i_cmd.ready is low while a command is in work. The result sits in an output
// register, so a new command is taken while it waits; if o_res.ready is still
// low when the next result is due, the core holds in its last step.
// Reset (i_rst_n, synchronous) restores the register defaults, the live and
// staged compares (quarter and three quarters of the default period), clears
// pending and drops o_res.valid. APB registers at word-aligned byte addresses.
`include "voltage_to_pwm_compare_core_assert.svh"

module voltage_to_pwm_compare_core #(
    parameter int COUNT_WIDTH = vpc_pkg::VPC_COUNT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    vpc_cmd_if.sink                      i_cmd,
    vpc_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vpc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int          CW16     = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
    localparam logic [15:0] CntMask  = 16'((32'd1 << CW16) - 32'd1);
    localparam logic [15:0] RiseRst  = 16'(vpc_pkg::PERIOD_RST / 4) & CntMask;
    localparam logic [15:0] FallRst  = 16'((3 * vpc_pkg::PERIOD_RST) / 4) & CntMask;
    localparam int          CNT_W    = $clog2(vpc_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CntLast = CNT_W'(vpc_pkg::DIV_STEPS - 1);

    // Wrap a compare value to the counter width, keep 16 bits
    function automatic logic [15:0] cnt_wrap(input logic [17:0] v);
        cnt_wrap = v[15:0] & CntMask;
    endfunction

    // ---------------- configuration registers ----------------
    logic [15:0] r_pwm_period, r_supply_mv, r_limit_mv;
    logic [1:0]  r_frac_offset;
    logic        r_center, r_use_frac;
    logic        cfg_wr;
    logic [vpc_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[vpc_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= vpc_pkg::PERIOD_RST;
            r_supply_mv   <= vpc_pkg::SUPPLY_RST;
            r_limit_mv    <= vpc_pkg::LIMIT_RST;
            r_frac_offset <= vpc_pkg::FRAC_OFS_RST;
            r_center      <= vpc_pkg::CENTER_RST;
            r_use_frac    <= vpc_pkg::USE_FRAC_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                vpc_pkg::REG_PWM_PERIOD:   r_pwm_period  <= pwdata[15:0];
                vpc_pkg::REG_SUPPLY_MV:    r_supply_mv   <= pwdata[15:0];
                vpc_pkg::REG_LIMIT_MV:     r_limit_mv    <= pwdata[15:0];
                vpc_pkg::REG_FRAC_OFFSET:  r_frac_offset <= pwdata[1:0];
                vpc_pkg::REG_CENTER_ALIGN: r_center      <= pwdata[0];
                vpc_pkg::REG_USE_FRACTION: r_use_frac    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (cfg_idx)
            vpc_pkg::REG_PWM_PERIOD:   prdata = {16'd0, r_pwm_period};
            vpc_pkg::REG_SUPPLY_MV:    prdata = {16'd0, r_supply_mv};
            vpc_pkg::REG_LIMIT_MV:     prdata = {16'd0, r_limit_mv};
            vpc_pkg::REG_FRAC_OFFSET:  prdata = {30'd0, r_frac_offset};
            vpc_pkg::REG_CENTER_ALIGN: prdata = {31'd0, r_center};
            vpc_pkg::REG_USE_FRACTION: prdata = {31'd0, r_use_frac};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------- control ----------------
    vpc_pkg::t_state r_state, n_state;
    vpc_pkg::t_func  r_func, cmd_func;
    logic            cmd_fire, out_free, finish;
    logic [CNT_W-1:0] r_cnt;
    logic            r_out_valid;

    assign cmd_func    = vpc_pkg::t_func'(i_cmd.func);
    assign i_cmd.ready = (r_state == vpc_pkg::S_IDLE);
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign finish      = (r_state == vpc_pkg::S_PLACE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vpc_pkg::S_IDLE: begin
                if (cmd_fire) begin
                    n_state = (cmd_func == vpc_pkg::FN_COMMIT) ? vpc_pkg::S_PLACE
                                                                : vpc_pkg::S_MUL;
                end
            end
            vpc_pkg::S_MUL:   n_state = vpc_pkg::S_LOAD;
            vpc_pkg::S_LOAD:  n_state = vpc_pkg::S_DIV;
            vpc_pkg::S_DIV: begin
                if (r_cnt == CntLast) n_state = vpc_pkg::S_CLAMP;
            end
            vpc_pkg::S_CLAMP: n_state = vpc_pkg::S_PLACE;
            vpc_pkg::S_PLACE: begin
                if (out_free) n_state = vpc_pkg::S_IDLE;
            end
            default:          n_state = vpc_pkg::S_IDLE;
        endcase
    end

    // ---------------- operand preparation at command transfer ----------------
    logic signed [16:0] spd, lim_s, spd_c;
    logic [15:0]        sup;
    logic signed [17:0] volt_x;
    logic [13:0]        duty_c;
    logic [16:0]        p1;
    logic               is_duty;
    logic [19:0]        op_a;
    logic signed [17:0] op_b;
    logic [16:0]        op_add, op_div;

    assign p1 = {1'b0, r_pwm_period} + 17'd1;

    always_comb begin
        spd    = {i_cmd.speed_mv[15], i_cmd.speed_mv};
        lim_s  = $signed({1'b0, r_limit_mv});
        if (spd < -lim_s)     spd_c = -lim_s;
        else if (spd > lim_s) spd_c = lim_s;
        else                  spd_c = spd;
        sup    = (r_supply_mv == 16'd0) ? 16'd1 : r_supply_mv;
        volt_x = {spd_c[16], spd_c} + $signed({2'b00, sup});

        if (i_cmd.duty_centi < 15'sd0)
            duty_c = 14'd0;
        else if (i_cmd.duty_centi > $signed({1'b0, vpc_pkg::DUTY_FULL}))
            duty_c = vpc_pkg::DUTY_FULL;
        else
            duty_c = i_cmd.duty_centi[13:0];

        is_duty = (cmd_func == vpc_pkg::FN_APPLY_DUTY);
        op_b    = is_duty ? $signed({4'b0000, duty_c}) : volt_x;
        if (r_center) begin
            op_a   = is_duty ? {p1, 3'b000} : {1'b0, p1, 2'b00};
            op_add = is_duty ? vpc_pkg::DUTY_CENTER_RND : {1'b0, sup};
            op_div = is_duty ? vpc_pkg::DUTY_CENTER_DIV : {sup, 1'b0};
        end else begin
            op_a   = {4'b0000, r_pwm_period};
            op_add = 17'd0;
            op_div = is_duty ? vpc_pkg::DUTY_EDGE_DIV : {sup, 1'b0};
        end
    end

    // ---------------- shared multiply / serial divide ----------------
    logic [19:0]        r_mul_a;
    logic signed [17:0] r_mul_b;
    logic [16:0]        r_add, r_div;
    logic signed [38:0] r_prod;
    logic signed [39:0] num;
    logic [35:0]        r_quo;
    logic [16:0]        r_rem;
    logic [17:0]        rem_sh;
    logic [18:0]        rem_diff;

    assign num      = {r_prod[38], r_prod} + $signed({23'd0, r_add});
    assign rem_sh   = {r_rem, r_quo[35]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_func  <= cmd_func;
            r_mul_a <= op_a;
            r_mul_b <= op_b;
            r_add   <= op_add;
            r_div   <= op_div;
        end
        // product, one pass
        if (r_state == vpc_pkg::S_MUL) begin
            r_prod <= $signed({1'b0, r_mul_a}) * r_mul_b;
        end
        // non-positive numerator gives zero
        if (r_state == vpc_pkg::S_LOAD) begin
            r_quo <= (num[39] || num == 40'sd0) ? 36'd0 : num[35:0];
            r_rem <= 17'd0;
            r_cnt <= '0;
        end
        // restoring divide, one bit per cycle
        if (r_state == vpc_pkg::S_DIV) begin
            r_cnt <= r_cnt + 1'b1;
            if (!rem_diff[18]) begin
                r_rem <= rem_diff[16:0];
                r_quo <= {r_quo[34:0], 1'b1};
            end else begin
                r_rem <= rem_sh[16:0];
                r_quo <= {r_quo[34:0], 1'b0};
            end
        end
    end

    // ---------------- clamp and fraction carry ----------------
    logic [18:0] d_lim, d_min, d_adj;
    logic [2:0]  frac_sum;
    logic [1:0]  frac_c;
    logic [18:0] r_d;
    logic [1:0]  r_frac;

    always_comb begin
        d_lim    = r_center ? {p1, 2'b00} : {3'b000, r_pwm_period};
        d_min    = (r_quo > {17'd0, d_lim}) ? d_lim : r_quo[18:0];
        frac_sum = {1'b0, d_min[1:0]} + {1'b0, r_frac_offset};
        if (!r_center) begin
            frac_c = 2'd0;
            d_adj  = d_min;
        end else if (r_use_frac) begin
            frac_c = frac_sum[1:0];
            d_adj  = d_min + {16'd0, frac_sum[2], 2'b00};
        end else begin
            frac_c = r_frac_offset;
            d_adj  = d_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == vpc_pkg::S_CLAMP) begin
            r_d    <= d_adj;
            r_frac <= frac_c;
        end
    end

    // ---------------- placement in the period ----------------
    logic [16:0] w, p1_w, off;
    logic [15:0] res_rise, res_fall;

    always_comb begin
        w    = r_d[18:2];
        p1_w = p1 - w;
        off  = (w > p1) ? 17'd0 : {1'b0, p1_w[16:1]};
        if (!r_center) begin
            res_rise = cnt_wrap({2'b00, r_d[15:0]});
            res_fall = cnt_wrap({2'b00, r_pwm_period});
        end else if (r_d == 19'd0) begin
            res_rise = cnt_wrap({1'b0, p1});
            res_fall = 16'd0;
        end else begin
            res_rise = cnt_wrap({1'b0, off});
            res_fall = cnt_wrap({1'b0, off} + {1'b0, w});
        end
    end

    // ---------------- live / staged state ----------------
    logic [15:0] r_live_rise, r_live_fall, r_stg_rise, r_stg_fall;
    logic [1:0]  r_live_frac, r_stg_frac;
    logic        r_staged_valid;
    logic [15:0] n_live_rise, n_live_fall;
    logic [1:0]  n_live_frac;
    logic        n_staged_valid, n_applied;

    always_comb begin
        n_live_rise    = r_live_rise;
        n_live_fall    = r_live_fall;
        n_live_frac    = r_live_frac;
        n_staged_valid = r_staged_valid;
        n_applied      = 1'b0;
        case (r_func)
            vpc_pkg::FN_APPLY_V, vpc_pkg::FN_APPLY_DUTY: begin
                n_live_rise = res_rise;
                n_live_fall = res_fall;
                n_live_frac = r_frac;
                n_applied   = 1'b1;
            end
            vpc_pkg::FN_STAGE_V: begin
                n_staged_valid = 1'b1;
            end
            vpc_pkg::FN_COMMIT: begin
                if (r_staged_valid) begin
                    n_live_rise    = r_stg_rise;
                    n_live_fall    = r_stg_fall;
                    n_live_frac    = r_stg_frac;
                    n_staged_valid = 1'b0;
                    n_applied      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_rise    <= RiseRst;
            r_live_fall    <= FallRst;
            r_live_frac    <= vpc_pkg::FRAC_OFS_RST;
            r_stg_rise     <= RiseRst;
            r_stg_fall     <= FallRst;
            r_stg_frac     <= 2'd0;
            r_staged_valid <= 1'b0;
        end else if (finish) begin
            r_live_rise    <= n_live_rise;
            r_live_fall    <= n_live_fall;
            r_live_frac    <= n_live_frac;
            r_staged_valid <= n_staged_valid;
            if (r_func == vpc_pkg::FN_STAGE_V) begin
                r_stg_rise <= res_rise;
                r_stg_fall <= res_fall;
                r_stg_frac <= r_frac;
            end
        end
    end

    // ---------------- output register ----------------
    logic [15:0] r_out_rise, r_out_fall;
    logic [1:0]  r_out_frac;
    logic        r_out_pending, r_out_applied;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_rise    <= n_live_rise;
            r_out_fall    <= n_live_fall;
            r_out_frac    <= n_live_frac;
            r_out_pending <= n_staged_valid;
            r_out_applied <= n_applied;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.rise_compare  = r_out_rise;
    assign o_res.fall_compare  = r_out_fall;
    assign o_res.fraction_bits = r_out_frac;
    assign o_res.pending       = r_out_pending;
    assign o_res.applied       = r_out_applied;

    // ---------------- assertions ----------------
    `VPC_ASSERT_NEXT(a_cmd_starts, cmd_fire, r_state == vpc_pkg::S_MUL || r_state == vpc_pkg::S_PLACE, "command transfer did not start the sequencer")
    `VPC_ASSERT_NOW(a_load_from_place, $rose(r_out_valid), $past(r_state == vpc_pkg::S_PLACE), "result loaded outside the placement step")
    `VPC_ASSERT_NOW(a_div_count, r_state == vpc_pkg::S_DIV, r_cnt <= CntLast, "divider step count overran")
    `VPC_ASSERT_NOW(a_pending_tracks, r_out_valid, r_out_pending == r_staged_valid, "pending flag disagrees with staged state")

endmodule
